// File: design/cotb_pkg.sv
package cotb_pkg;

  localparam int unsigned IdxW = 3;
  localparam int unsigned MaskW = 8;
  localparam int unsigned IdW = 16;
  localparam int unsigned MsW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [2:0] {
    OP_PRESS   = 3'd0,
    OP_TIMED   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_STUCK   = 3'd3,
    OP_LEVEL   = 3'd4,
    OP_ALL_OFF = 3'd5,
    OP_TICK    = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_FOLLOW = 2'd1,
    MODE_PULSE  = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FOLLOW_LIMIT = 1'd0,
    REG_PULSE_LENGTH = 1'd1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            ready;
    logic            step;
    logic [IdxW-1:0] idx;
    logic            load_out;
  } ctrl_t;

endpackage

// File: design/cotb_if.sv
interface cotb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  jack;
  logic [1:0]  press_mode;
  logic [15:0] press_id;
  logic [15:0] duration_ms;
  logic [31:0] now_ms;

  modport source (
    output valid, operation, jack, press_mode, press_id, duration_ms, now_ms,
    input  ready
  );
  modport sink (
    input  valid, operation, jack, press_mode, press_id, duration_ms, now_ms,
    output ready
  );
endinterface

interface cotb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] closed_mask;

  modport source (
    output valid, closed_mask,
    input  ready
  );
  modport sink (
    input  valid, closed_mask,
    output ready
  );
endinterface

// File: design/cotb_alu.sv
module cotb_alu
  import cotb_pkg::*;
(
  input  logic [TimeW-1:0] a_i,
  input  logic [TimeW-1:0] b_i,
  input  logic             sub_i,
  output logic [TimeW-1:0] sum_o,
  output logic [TimeW-1:0] deadline_o
);

  logic [TimeW-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + TimeW'(sub_i);
  // a sum that wraps to zero would read as no deadline
  assign deadline_o = (sum_o == '0) ? TimeW'(1) : sum_o;

endmodule

// File: design/cotb_ctrl.sv
module cotb_ctrl
  import cotb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic            work_i,
  input  logic [IdxW-1:0] first_i,
  input  logic [IdxW-1:0] last_i,
  input  logic            out_free_i,
  output ctrl_t           ctrl_o
);

  state_e          state_q, state_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [IdxW-1:0] last_q, last_d;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    last_d  = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire_i) begin
          k_d     = first_i;
          last_d  = last_i;
          state_d = work_i ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (k_q == last_q) begin
          state_d = ST_DONE;
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.ready    = 1'b0;
    ctrl_o.step     = 1'b0;
    ctrl_o.idx      = k_q;
    ctrl_o.load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: ctrl_o.ready    = 1'b1;
      ST_RUN:  ctrl_o.step     = 1'b1;
      ST_DONE: ctrl_o.load_out = out_free_i;
      default: ctrl_o.ready    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      last_q  <= last_d;
    end
  end

endmodule

// File: design/contact_output_timer_bank_core.sv
// bank of up to eight contact-closure outputs with per-output deadlines
//
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 follow limit,
// 1 pulse length) at the clock edge; write only while the block is idle
// input: in_i carries one operation word; accepted when valid and ready
// output: out_o returns one word per operation, the mask of closed outputs
//
// one shared 32-bit add/subtract unit is walked over the outputs by a small
// sequencer; a jack operation takes one step, a bank-wide operation (level
// change, all off, tick) takes OUTPUT_COUNT steps, one output per cycle
// sequence: accept, then the steps, then loading of the output register once it is
// free; ready is low from accept until the result is loaded, so a new word is
// taken only after the previous result has gone into the output register
// stall: a waiting result sits in the output register and the next word is
// still accepted; the block then holds its finished result until the register frees
// reset: all outputs open, follow limit 0, pulse length 100 ms
module contact_output_timer_bank_core
  import cotb_pkg::*;
#(
  parameter int unsigned OUTPUT_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MsW-1:0]     cfg_data_i,
  cotb_in_if.sink            in_i,
  cotb_out_if.source         out_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(OUTPUT_COUNT - 1);

  logic [MsW-1:0] follow_limit_q;
  logic [MsW-1:0] pulse_length_q;

  logic [OUTPUT_COUNT-1:0] closed_q;
  logic [OUTPUT_COUNT-1:0] follow_q;
  logic [IdW-1:0]          owner_q [OUTPUT_COUNT];
  logic [TimeW-1:0]        dl_q [OUTPUT_COUNT];

  op_e              op_q;
  mode_e            mode_q;
  logic [IdW-1:0]   pid_q;
  logic [MsW-1:0]   dur_q;
  logic [TimeW-1:0] now_q;

  logic             out_valid_q;
  logic [MaskW-1:0] mask_q;
  logic [MaskW-1:0] mask;

  ctrl_t ctrl;
  logic  fire;
  logic  out_free;
  logic  work;
  logic  bank_op;
  logic  jack_ok;
  op_e   in_op;
  mode_e in_mode;
  logic [IdxW-1:0] first_idx;
  logic [IdxW-1:0] last_idx;

  logic [MsW-1:0]   len;
  logic             alu_sub;
  logic [TimeW-1:0] alu_b;
  logic [TimeW-1:0] alu_sum;
  logic [TimeW-1:0] alu_dl;

  logic             cur_closed;
  logic             cur_follow;
  logic [IdW-1:0]   cur_owner;
  logic [TimeW-1:0] cur_dl;
  logic             set_en;
  logic             clr_en;
  logic             set_follow;
  logic [IdW-1:0]   set_owner;
  logic [TimeW-1:0] set_dl;

  assign in_op    = op_e'(in_i.operation);
  assign in_mode  = mode_e'(in_i.press_mode);
  assign fire     = in_i.valid && ctrl.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign jack_ok  = in_i.jack < 8'(OUTPUT_COUNT);

  // decide at accept whether the word touches state and which outputs it walks
  always_comb begin
    work    = 1'b0;
    bank_op = 1'b0;
    unique case (in_op) inside
      OP_PRESS: work = jack_ok && (in_mode == MODE_FOLLOW || in_mode == MODE_PULSE);
      OP_TIMED, OP_RELEASE, OP_STUCK: work = jack_ok;
      OP_LEVEL, OP_ALL_OFF, OP_TICK: begin
        work    = 1'b1;
        bank_op = 1'b1;
      end
      default: work = 1'b0;
    endcase
  end

  assign first_idx = bank_op ? '0 : in_i.jack[IdxW-1:0];
  assign last_idx  = bank_op ? LastIdx : in_i.jack[IdxW-1:0];

  cotb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .work_i     (work),
    .first_i    (first_idx),
    .last_i     (last_idx),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_limit_q <= '0;
      pulse_length_q <= MsW'(100);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_FOLLOW_LIMIT: follow_limit_q <= cfg_data_i;
        REG_PULSE_LENGTH: pulse_length_q <= cfg_data_i;
        default:          follow_limit_q <= follow_limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      op_q   <= in_op;
      mode_q <= in_mode;
      pid_q  <= in_i.press_id;
      dur_q  <= in_i.duration_ms;
      now_q  <= in_i.now_ms;
    end
  end

  // current output
  assign cur_closed = closed_q[ctrl.idx];
  assign cur_follow = follow_q[ctrl.idx];
  assign cur_owner  = owner_q[ctrl.idx];
  assign cur_dl     = dl_q[ctrl.idx];

  always_comb begin
    len = dur_q;
    if (op_q == OP_PRESS) begin
      len = (mode_q == MODE_FOLLOW) ? follow_limit_q : pulse_length_q;
    end
  end

  assign alu_sub = (op_q == OP_TICK);
  assign alu_b   = alu_sub ? cur_dl : TimeW'(len);

  cotb_alu u_alu (
    .a_i        (now_q),
    .b_i        (alu_b),
    .sub_i      (alu_sub),
    .sum_o      (alu_sum),
    .deadline_o (alu_dl)
  );

  always_comb begin
    set_en     = 1'b0;
    clr_en     = 1'b0;
    set_follow = 1'b0;
    set_owner  = '0;
    set_dl     = alu_dl;
    unique case (op_q) inside
      OP_PRESS: begin
        set_en     = 1'b1;
        set_owner  = pid_q;
        set_follow = (mode_q == MODE_FOLLOW);
        if (mode_q == MODE_FOLLOW && follow_limit_q == '0) begin
          set_dl = '0;
        end
      end
      OP_TIMED:   set_en = 1'b1;
      OP_RELEASE: clr_en = cur_closed && cur_follow && (cur_owner == pid_q);
      OP_STUCK, OP_LEVEL: clr_en = cur_closed && cur_follow;
      OP_ALL_OFF: clr_en = 1'b1;
      OP_TICK:    clr_en = cur_closed && (cur_dl != '0) && !alu_sum[TimeW-1];
      default:    clr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= '0;
      follow_q <= '0;
      for (int k = 0; k < OUTPUT_COUNT; k++) begin
        owner_q[k] <= '0;
        dl_q[k]    <= '0;
      end
    end else if (ctrl.step) begin
      if (set_en) begin
        closed_q[ctrl.idx] <= 1'b1;
        follow_q[ctrl.idx] <= set_follow;
        owner_q[ctrl.idx]  <= set_owner;
        dl_q[ctrl.idx]     <= set_dl;
      end else if (clr_en) begin
        closed_q[ctrl.idx] <= 1'b0;
        follow_q[ctrl.idx] <= 1'b0;
        owner_q[ctrl.idx]  <= '0;
        dl_q[ctrl.idx]     <= '0;
      end
    end
  end

  always_comb begin
    mask = '0;
    mask[OUTPUT_COUNT-1:0] = closed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      mask_q <= mask;
    end
  end

  assign in_i.ready        = ctrl.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.closed_mask = mask_q;

endmodule

// File: sim/contact_output_timer_bank_core_tb.sv
`timescale 1ns / 1ps

module contact_output_timer_bank_core_tb;
  import cotb_pkg::*;

  localparam int unsigned NOUT = 8;
  localparam int unsigned DRAIN_CYCLES = NOUT + 4;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_WORDS = 275;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    op_e         op;
    logic [7:0]  jack;
    mode_e       mode;
    logic [15:0] pid;
    logic [15:0] dur;
    logic [31:0] now;
  } word_t;

  typedef struct packed {
    word_t      w;
    logic       typed;
    logic [7:0] mask;
  } row_t;

  localparam int unsigned ROW_COUNT = 25;
  localparam row_t DIRECTED [ROW_COUNT] = '{
    '{'{OP_TICK,    8'd0,   MODE_OFF,    16'h0000, 16'd0,     32'h0000_0000}, 1'b1, 8'h00},
    '{'{OP_PRESS,   8'd0,   MODE_FOLLOW, 16'hFFFF, 16'd0,     32'h0000_0000}, 1'b1, 8'h01},
    '{'{OP_PRESS,   8'd7,   MODE_PULSE,  16'h0000, 16'd0,     32'hFFFF_FF9C}, 1'b1, 8'h81},
    '{'{OP_TICK,    8'd0,   MODE_OFF,    16'h0000, 16'd0,     32'h0000_0000}, 1'b0, 8'h00},
    '{'{OP_TICK,    8'd0,   MODE_OFF,    16'h0000, 16'd0,     32'h0000_0001}, 1'b0, 8'h00},
    '{'{OP_PRESS,   8'd1,   MODE_OFF,    16'h0001, 16'd0,     32'h0000_0002}, 1'b0, 8'h00},
    '{'{OP_PRESS,   8'd2,   MODE_RSVD,   16'h0001, 16'd0,     32'h0000_0002}, 1'b0, 8'h00},
    '{'{OP_PRESS,   8'd8,   MODE_FOLLOW, 16'h0002, 16'd0,     32'h0000_0003}, 1'b0, 8'h00},
    '{'{OP_PRESS,   8'd255, MODE_PULSE,  16'h0002, 16'd0,     32'h0000_0003}, 1'b0, 8'h00},
    '{'{OP_TIMED,   8'd3,   MODE_OFF,    16'h1234, 16'hFFFF,  32'hFFFF_0001}, 1'b0, 8'h00},
    '{'{OP_TIMED,   8'd255, MODE_OFF,    16'h0000, 16'd5,     32'h0000_0004}, 1'b0, 8'h00},
    '{'{OP_RELEASE, 8'd0,   MODE_OFF,    16'hFFFE, 16'd0,     32'h0000_0005}, 1'b0, 8'h00},
    '{'{OP_RELEASE, 8'd3,   MODE_OFF,    16'h0000, 16'd0,     32'h0000_0005}, 1'b0, 8'h00},
    '{'{OP_RELEASE, 8'd0,   MODE_OFF,    16'hFFFF, 16'd0,     32'h0000_0006}, 1'b0, 8'h00},
    '{'{OP_PRESS,   8'd1,   MODE_FOLLOW, 16'h0005, 16'd0,     32'h0000_000A}, 1'b0, 8'h00},
    '{'{OP_STUCK,   8'd3,   MODE_OFF,    16'h0000, 16'd0,     32'h0000_000B}, 1'b0, 8'h00},
    '{'{OP_STUCK,   8'd1,   MODE_OFF,    16'h0000, 16'd0,     32'h0000_000B}, 1'b0, 8'h00},
    '{'{OP_PRESS,   8'd2,   MODE_FOLLOW, 16'h0007, 16'd0,     32'h0000_000C}, 1'b0, 8'h00},
    '{'{OP_PRESS,   8'd4,   MODE_PULSE,  16'h0009, 16'd0,     32'h0000_0014}, 1'b0, 8'h00},
    '{'{OP_LEVEL,   8'd0,   MODE_OFF,    16'h0000, 16'd0,     32'h0000_0015}, 1'b0, 8'h00},
    '{'{OP_NONE,    8'd0,   MODE_OFF,    16'h0000, 16'd0,     32'h0000_0016}, 1'b0, 8'h00},
    '{'{OP_STUCK,   8'd200, MODE_OFF,    16'h0000, 16'd0,     32'h0000_0016}, 1'b0, 8'h00},
    '{'{OP_TICK,    8'd0,   MODE_OFF,    16'h0000, 16'd0,     32'h0000_00C8}, 1'b0, 8'h00},
    '{'{OP_TIMED,   8'd6,   MODE_OFF,    16'h0000, 16'd0,     32'h7FFF_FFFF}, 1'b0, 8'h00},
    '{'{OP_ALL_OFF, 8'd0,   MODE_OFF,    16'h0000, 16'd0,     32'h7FFF_FFFF}, 1'b1, 8'h00}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [MsW-1:0] cfg_data_i;

  cotb_in_if in_bus ();
  cotb_out_if out_bus ();

  contact_output_timer_bank_core #(
    .OUTPUT_COUNT(NOUT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // bank state as the block should hold it
  logic [15:0] follow_limit;
  logic [15:0] pulse_length;
  logic        closed_q [NOUT];
  logic        follow_q [NOUT];
  logic [15:0] owner_q [NOUT];
  logic [31:0] deadline_q [NOUT];

  logic [7:0] pending_masks [$];
  logic [31:0] clock_ms;
  int faults = 0;
  int masks_checked = 0;
  int words_sent;
  int settings_used;
  int op_seen [8];
  int sender_calm;
  int stall_left = 0;
  int calm_left = 0;

  function automatic logic [31:0] due_at(logic [31:0] now, logic [31:0] len);
    logic [31:0] sum;
    sum = now + len;
    return (sum == 32'd0) ? 32'd1 : sum;
  endfunction

  function automatic void open_contact(int k);
    closed_q[k] = 1'b0;
    follow_q[k] = 1'b0;
    owner_q[k] = 16'd0;
    deadline_q[k] = 32'd0;
  endfunction

  function automatic logic [7:0] bank_step(word_t w);
    logic [7:0] mask;
    logic [31:0] diff;
    int j;
    bit jack_ok;
    jack_ok = (w.jack < NOUT);
    j = jack_ok ? int'(w.jack) : 0;
    case (w.op)
      OP_PRESS: begin
        if (jack_ok && (w.mode == MODE_FOLLOW || w.mode == MODE_PULSE)) begin
          closed_q[j] = 1'b1;
          owner_q[j] = w.pid;
          if (w.mode == MODE_FOLLOW) begin
            follow_q[j] = 1'b1;
            deadline_q[j] = (follow_limit != 16'd0) ? due_at(w.now, {16'd0, follow_limit})
                                                    : 32'd0;
          end else begin
            follow_q[j] = 1'b0;
            deadline_q[j] = due_at(w.now, {16'd0, pulse_length});
          end
        end
      end
      OP_TIMED: begin
        if (jack_ok) begin
          closed_q[j] = 1'b1;
          follow_q[j] = 1'b0;
          owner_q[j] = 16'd0;
          deadline_q[j] = due_at(w.now, {16'd0, w.dur});
        end
      end
      OP_RELEASE: begin
        if (jack_ok && closed_q[j] && follow_q[j] && owner_q[j] == w.pid) open_contact(j);
      end
      OP_STUCK: begin
        if (jack_ok && closed_q[j] && follow_q[j]) open_contact(j);
      end
      OP_LEVEL: begin
        for (int k = 0; k < NOUT; k++) if (closed_q[k] && follow_q[k]) open_contact(k);
      end
      OP_ALL_OFF: begin
        for (int k = 0; k < NOUT; k++) open_contact(k);
      end
      OP_TICK: begin
        for (int k = 0; k < NOUT; k++) begin
          diff = w.now - deadline_q[k];
          if (closed_q[k] && deadline_q[k] != 32'd0 && !diff[31]) open_contact(k);
        end
      end
      default: begin
      end
    endcase
    mask = 8'd0;
    for (int k = 0; k < NOUT; k++) mask[k] = closed_q[k];
    return mask;
  endfunction

  function automatic int sender_gap();
    int r;
    if (sender_calm > 0) begin
      sender_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      sender_calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t random_word();
    word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) clock_ms = clock_ms + $urandom_range(0, 40);
    else if (r < 90) clock_ms = clock_ms + $urandom_range(0, 400);
    else if (r < 97) clock_ms = clock_ms + $urandom_range(0, 70000);
    else clock_ms = $urandom();
    w.now = clock_ms;
    r = $urandom_range(0, 99);
    if (r < 30) w.op = OP_PRESS;
    else if (r < 45) w.op = OP_TIMED;
    else if (r < 60) w.op = OP_RELEASE;
    else if (r < 68) w.op = OP_STUCK;
    else if (r < 73) w.op = OP_LEVEL;
    else if (r < 76) w.op = OP_ALL_OFF;
    else if (r < 98) w.op = OP_TICK;
    else w.op = OP_NONE;
    w.jack = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NOUT, 255))
                                         : 8'($urandom_range(0, NOUT - 1));
    r = $urandom_range(0, 99);
    w.mode = (r < 45) ? MODE_FOLLOW : (r < 88) ? MODE_PULSE : (r < 95) ? MODE_OFF : MODE_RSVD;
    w.pid = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom());
    if (w.op == OP_RELEASE && w.jack < NOUT && $urandom_range(0, 99) < 65)
      w.pid = owner_q[w.jack];
    w.dur = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 200)) : 16'($urandom());
    return w;
  endfunction

  task automatic send_word(input word_t w, input logic typed, input logic [7:0] typed_mask);
    logic [7:0] predicted;
    int gap;
    in_bus.valid = 1'b1;
    in_bus.operation = w.op;
    in_bus.jack = w.jack;
    in_bus.press_mode = w.mode;
    in_bus.press_id = w.pid;
    in_bus.duration_ms = w.dur;
    in_bus.now_ms = w.now;
    do @(posedge clk_i); while (!in_bus.ready);
    predicted = bank_step(w);
    pending_masks.push_back(typed ? typed_mask : predicted);
    words_sent++;
    op_seen[w.op]++;
    @(negedge clk_i);
    gap = sender_gap();
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_bank();
    in_bus.valid = 1'b0;
    while (pending_masks.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [15:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_FOLLOW_LIMIT) follow_limit = data;
    else pulse_length = data;
  endtask

  always @(negedge clk_i) begin
    int r;
    if (stall_left > 0) begin
      out_bus.ready = 1'b0;
      stall_left--;
    end else begin
      out_bus.ready = 1'b1;
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) calm_left = $urandom_range(50, 300);
        else if (r < 30) stall_left = $urandom_range(1, 3);
        else if (r < 33) stall_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_masks.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("unexpected mask %02h with nothing pending", out_bus.closed_mask);
      end else begin
        want = pending_masks.pop_front();
        masks_checked++;
        if (out_bus.closed_mask !== want) begin
          faults++;
          if (faults <= MAX_REPORTS)
            $display("closed_mask mismatch: expected %02h got %02h", want, out_bus.closed_mask);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL contact_output_timer_bank_core");
    $finish;
  end

  initial begin
    logic [15:0] phase_limit [PHASES];
    logic [15:0] phase_pulse [PHASES];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FOLLOW_LIMIT;
    cfg_data_i = '0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_NONE;
    in_bus.jack = '0;
    in_bus.press_mode = MODE_OFF;
    in_bus.press_id = '0;
    in_bus.duration_ms = '0;
    in_bus.now_ms = '0;
    sender_calm = 0;
    words_sent = 0;
    settings_used = 1;
    clock_ms = 32'd0;
    follow_limit = 16'd0;
    pulse_length = 16'd100;
    for (int k = 0; k < NOUT; k++) open_contact(k);
    for (int k = 0; k < 8; k++) op_seen[k] = 0;

    phase_limit = '{16'd65535, 16'd0, 16'd1, 16'd250, 16'd65535, 16'($urandom())};
    phase_pulse = '{16'd0, 16'd65535, 16'd1, 16'd40, 16'd65535, 16'($urandom())};

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < ROW_COUNT; i++)
      send_word(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].mask);

    for (int p = 0; p < PHASES; p++) begin
      drain_bank();
      write_reg(REG_FOLLOW_LIMIT, phase_limit[p]);
      write_reg(REG_PULSE_LENGTH, phase_pulse[p]);
      settings_used++;
      // run close to the wrap of the millisecond counter now and then
      clock_ms = (p % 2 == 1) ? 32'hFFFF_F000 + $urandom_range(0, 4000) : $urandom();
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i == PHASE_WORDS / 2) drain_bank();
        send_word(random_word(), 1'b0, 8'h00);
      end
    end

    drain_bank();
    $display("sent %0d words over %0d register settings, %0d masks checked",
             words_sent, settings_used, masks_checked);
    $display("presses %0d, timed %0d, releases %0d, stuck %0d, level %0d, all off %0d, ticks %0d",
             op_seen[OP_PRESS], op_seen[OP_TIMED], op_seen[OP_RELEASE], op_seen[OP_STUCK],
             op_seen[OP_LEVEL], op_seen[OP_ALL_OFF], op_seen[OP_TICK]);
    if (faults == 0 && pending_masks.size() == 0) begin
      $display("PASS contact_output_timer_bank_core");
    end else begin
      $display("FAIL contact_output_timer_bank_core");
    end
    $finish;
  end

endmodule

// File: contact_output_timer_bank_core.f
design/cotb_pkg.sv
design/cotb_if.sv
design/cotb_alu.sv
design/cotb_ctrl.sv
design/contact_output_timer_bank_core.sv
sim/contact_output_timer_bank_core_tb.sv
